[design/mdaag_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mdaag_pkg
// Shared types and codes of the multi-dimensional array address generator.
// ----------------------------------------------------------------------------
package mdaag_pkg;

  localparam int NUM_DIMS   = 4;
  localparam int COORD_BITS = 16;
  localparam int CFG_BITS   = 64;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [1:0] OP_ROW   = 2'd0;
  localparam logic [1:0] OP_COL   = 2'd1;
  localparam logic [1:0] OP_DELIN = 2'd2;

  localparam logic [CFG_IDX_BITS-1:0] CFG_DIM_COUNT    = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_LOWER_BOUNDS = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_UPPER_BOUNDS = 2'd2;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [15:0] index_0;
    logic signed [15:0] index_1;
    logic signed [15:0] index_2;
    logic signed [15:0] index_3;
    logic [31:0]        linear_index;
  } in_t;

  typedef struct packed {
    logic [31:0]        linear_address;
    logic signed [15:0] row_coord_0;
    logic signed [15:0] row_coord_1;
    logic signed [15:0] row_coord_2;
    logic signed [15:0] row_coord_3;
    logic signed [15:0] col_coord_0;
    logic signed [15:0] col_coord_1;
    logic signed [15:0] col_coord_2;
    logic signed [15:0] col_coord_3;
    logic               out_of_range;
  } out_t;

endpackage
`default_nettype wire

[design/multi_dim_array_address_gen_top.sv]
// Throughput: one transaction per cycle while out_stall_i is low; the four linearization
// stages each hold one multiplier and the delinearize dividers retire four quotient bits per stage.
// A stage advances whenever it is empty or its successor advances, so bubbles fill up.
// Reset clears all valid bits and sets dim_count to 1 and both bound registers to zero.
`default_nettype none
// ----------------------------------------------------------------------------
// multi_dim_array_address_gen_top
// Row-major / column-major linearization and delinearization for arrays of up
// to four dimensions with configured signed bounds.
// ----------------------------------------------------------------------------
module multi_dim_array_address_gen_top #(
  parameter int MAX_DIMS   = 4,
  parameter int BOUND_BITS = 16,
  parameter int ADDR_BITS  = 32
) (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   cfg_we_i,
  input  wire  [mdaag_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  wire  [mdaag_pkg::CFG_BITS-1:0]        cfg_wdata_i,
  input  wire                                   in_valid_i,
  output logic                                  in_stall_o,
  input  mdaag_pkg::in_t                        in_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output mdaag_pkg::out_t                       out_o
);

  localparam int RW     = BOUND_BITS + 2;
  localparam int W      = RW + ADDR_BITS;
  localparam int SW     = ADDR_BITS + BOUND_BITS + 2;
  localparam int STEP   = 4;
  localparam int TOTAL  = MAX_DIMS * ADDR_BITS;
  localparam int NDS    = (TOTAL + STEP - 1) / STEP;
  localparam int S_FIN  = 5;
  localparam int NST    = S_FIN + 1 + NDS;

  typedef struct packed {
    logic [1:0]                     op;
    logic                           oor;
    logic                           big;
    logic                           zext;
    logic                           lbad;
    logic [ADDR_BITS-1:0]           acc;
    logic [ADDR_BITS-1:0]           lin;
    logic [3:0][BOUND_BITS-1:0]     off;
    logic [W-1:0]                   row_x;
    logic [W-1:0]                   col_x;
    logic [3:0][15:0]               row_c;
    logic [3:0][15:0]               col_c;
  } pipe_t;

  // Configuration registers.
  logic [2:0]  dim_count_q;
  logic [63:0] lower_bounds_q;
  logic [63:0] upper_bounds_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim_count_q    <= 3'd1;
      lower_bounds_q <= '0;
      upper_bounds_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        mdaag_pkg::CFG_DIM_COUNT:    dim_count_q    <= cfg_wdata_i[2:0];
        mdaag_pkg::CFG_LOWER_BOUNDS: lower_bounds_q <= cfg_wdata_i;
        mdaag_pkg::CFG_UPPER_BOUNDS: upper_bounds_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Derived from configuration; it must only change while the pipeline is empty, which the block does not enforce.
  logic [2:0]                   d_use;
  int                           dn;
  logic signed [BOUND_BITS-1:0] lo_w [4];
  logic signed [BOUND_BITS-1:0] hi_w [4];
  logic        [BOUND_BITS:0]   ext_w [4];

  always_comb begin
    logic signed [17:0] df;
    if (dim_count_q == 3'd0) begin
      d_use = 3'd1;
    end else if (32'(dim_count_q) > MAX_DIMS) begin
      d_use = 3'(MAX_DIMS);
    end else begin
      d_use = dim_count_q;
    end
    dn = int'(d_use);
    for (int k = 0; k < 4; k++) begin
      lo_w[k] = lower_bounds_q[16*k +: BOUND_BITS];
      hi_w[k] = upper_bounds_q[16*k +: BOUND_BITS];
      df = 18'(hi_w[k]) - 18'(lo_w[k]) + 18'sd1;
      ext_w[k] = (hi_w[k] >= lo_w[k]) ? (BOUND_BITS+1)'(df) : '0;
    end
  end

  function automatic logic [W-1:0] div_step(input logic [W-1:0] x,
                                            input logic [BOUND_BITS:0] dv,
                                            input logic first);
    logic [W-1:0]  y;
    logic [RW-1:0] top;
    y = x;
    if (first) begin
      y[W-1:ADDR_BITS] = '0;
    end
    y = y << 1;
    top = y[W-1:ADDR_BITS];
    if (top >= RW'(dv)) begin
      y[W-1:ADDR_BITS] = top - RW'(dv);
      y[0] = 1'b1;
    end
    return y;
  endfunction

  pipe_t            pipe_q [NST];
  pipe_t            pipe_d [NST];
  logic [NST-1:0]   valid_q;
  logic [NST:0]     adv;

  assign adv[NST]   = !out_stall_i;
  assign in_stall_o = !adv[0];

  genvar s;
  generate
    for (s = 0; s < NST; s++) begin : g_stage
      assign adv[s] = !valid_q[s] || adv[s+1];

      if (s == 0) begin : g_entry
        always_comb begin
          logic signed [15:0] idx [4];
          logic signed [16:0] ix;
          logic signed [16:0] lo17;
          logic signed [16:0] hi17;
          logic signed [16:0] dif;
          idx[0] = in_i.index_0;
          idx[1] = in_i.index_1;
          idx[2] = in_i.index_2;
          idx[3] = in_i.index_3;
          pipe_d[s]       = '0;
          pipe_d[s].op    = in_i.op;
          pipe_d[s].lin   = in_i.linear_index[ADDR_BITS-1:0];
          pipe_d[s].lbad  = 33'(in_i.linear_index) >= (33'd1 << ADDR_BITS);
          pipe_d[s].acc   = (in_i.op == mdaag_pkg::OP_DELIN) ? ADDR_BITS'(1) : '0;
          for (int k = 0; k < 4; k++) begin
            ix   = 17'(idx[k]);
            lo17 = 17'(lo_w[k]);
            hi17 = 17'(hi_w[k]);
            dif  = ix - lo17;
            if (k < dn) begin
              if (ext_w[k] == '0) begin
                pipe_d[s].zext = 1'b1;
              end
              if (in_i.op == mdaag_pkg::OP_ROW || in_i.op == mdaag_pkg::OP_COL) begin
                if (ix < lo17 || ix > hi17) begin
                  pipe_d[s].oor = 1'b1;
                end else begin
                  pipe_d[s].off[k] = BOUND_BITS'(dif);
                end
              end
            end
          end
        end
      end else if (s <= 4) begin : g_mul
        localparam int I = s - 1;
        always_comb begin
          logic [1:0]    k;
          logic [SW-1:0] sum;
          logic          over;
          pipe_d[s] = pipe_q[s-1];
          k = (pipe_q[s-1].op == mdaag_pkg::OP_COL) ? 2'(dn - 1 - I) : 2'(I);
          sum = SW'(pipe_q[s-1].acc) * SW'(ext_w[k]) + SW'(pipe_q[s-1].off[k]);
          over = sum[SW-1:ADDR_BITS] != '0;
          if (I < dn) begin
            if (pipe_q[s-1].op == mdaag_pkg::OP_ROW || pipe_q[s-1].op == mdaag_pkg::OP_COL) begin
              if (!pipe_q[s-1].oor) begin
                pipe_d[s].oor = over;
                pipe_d[s].acc = sum[ADDR_BITS-1:0];
              end
            end else if (pipe_q[s-1].op == mdaag_pkg::OP_DELIN) begin
              // The total size saturates once it reaches the address space.
              if (!pipe_q[s-1].big) begin
                pipe_d[s].big = over;
                pipe_d[s].acc = sum[ADDR_BITS-1:0];
              end
            end
          end
        end
      end else if (s == S_FIN) begin : g_fin
        always_comb begin
          pipe_d[s] = pipe_q[s-1];
          if (pipe_q[s-1].op == mdaag_pkg::OP_DELIN) begin
            pipe_d[s].oor = pipe_q[s-1].lbad || pipe_q[s-1].zext ||
                            (!pipe_q[s-1].big && pipe_q[s-1].lin >= pipe_q[s-1].acc);
          end
          if (!(pipe_q[s-1].op == mdaag_pkg::OP_ROW || pipe_q[s-1].op == mdaag_pkg::OP_COL) ||
              pipe_q[s-1].oor) begin
            pipe_d[s].acc = '0;
          end
          pipe_d[s].row_x = W'(pipe_q[s-1].lin);
          pipe_d[s].col_x = W'(pipe_q[s-1].lin);
        end
      end else begin : g_div
        localparam int BASE = (s - S_FIN - 1) * STEP;
        always_comb begin
          int                  t;
          int                  j;
          int                  bp;
          logic                used;
          logic [1:0]          kr;
          logic [1:0]          kc;
          logic [BOUND_BITS:0] dvr;
          logic [BOUND_BITS:0] dvc;
          pipe_d[s] = pipe_q[s-1];
          for (int u = 0; u < STEP; u++) begin
            t    = BASE + u;
            j    = t / ADDR_BITS;
            bp   = t % ADDR_BITS;
            used = j < dn;
            // Row-major peels the last dimension first, column-major the first.
            kr   = 2'(dn - 1 - j);
            kc   = 2'(j);
            dvr  = used ? ext_w[kr] : (BOUND_BITS+1)'(1);
            dvc  = used ? ext_w[kc] : (BOUND_BITS+1)'(1);
            if (t < TOTAL) begin
              pipe_d[s].row_x = div_step(pipe_d[s].row_x, dvr, bp == 0);
              pipe_d[s].col_x = div_step(pipe_d[s].col_x, dvc, bp == 0);
              if (bp == ADDR_BITS - 1 && used) begin
                pipe_d[s].row_c[kr] = 16'(lo_w[kr]) + 16'(pipe_d[s].row_x[W-1:ADDR_BITS]);
                pipe_d[s].col_c[kc] = 16'(lo_w[kc]) + 16'(pipe_d[s].col_x[W-1:ADDR_BITS]);
              end
            end
          end
        end
      end

      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          valid_q[s] <= 1'b0;
        end else if (adv[s]) begin
          valid_q[s] <= (s == 0) ? in_valid_i : valid_q[(s == 0) ? 0 : s-1];
        end
      end

      always_ff @(posedge clk_i) begin
        if (adv[s]) begin
          pipe_q[s] <= pipe_d[s];
        end
      end
    end
  endgenerate

  logic show_c;
  assign show_c = pipe_q[NST-1].op == mdaag_pkg::OP_DELIN && !pipe_q[NST-1].oor;

  assign out_valid_o          = valid_q[NST-1];
  assign out_o.linear_address = 32'(pipe_q[NST-1].acc);
  assign out_o.out_of_range   = pipe_q[NST-1].oor;
  assign out_o.row_coord_0    = show_c ? pipe_q[NST-1].row_c[0] : '0;
  assign out_o.row_coord_1    = show_c ? pipe_q[NST-1].row_c[1] : '0;
  assign out_o.row_coord_2    = show_c ? pipe_q[NST-1].row_c[2] : '0;
  assign out_o.row_coord_3    = show_c ? pipe_q[NST-1].row_c[3] : '0;
  assign out_o.col_coord_0    = show_c ? pipe_q[NST-1].col_c[0] : '0;
  assign out_o.col_coord_1    = show_c ? pipe_q[NST-1].col_c[1] : '0;
  assign out_o.col_coord_2    = show_c ? pipe_q[NST-1].col_c[2] : '0;
  assign out_o.col_coord_3    = show_c ? pipe_q[NST-1].col_c[3] : '0;

`ifndef ASSERT_OFF
  // An out-of-range transaction never carries an address.
  a_oor_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.out_of_range |-> out_o.linear_address == '0)
    else $error("out-of-range result with nonzero address");

  // Input back-pressure only arises from output back-pressure.
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_stall_i)
    else $error("input stalled without output stall");

  // A completely full pipeline under output stall must stall the input.
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (&valid_q) && out_stall_i |-> in_stall_o)
    else $error("full pipeline accepted a transaction");

  // A held output transaction stays valid in the next cycle.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[NST-1] && out_stall_i |=> valid_q[NST-1] && $stable(pipe_q[NST-1].acc))
    else $error("stalled result lost");
`endif

endmodule
`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the multi-dimensional array address generator.
// Sweeps several bound and dimension settings and sends row-major, column-major,
// delinearize and unused requests under random backpressure. Every result is
// checked against a software model of the address math.
// ----------------------------------------------------------------------------
module tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam longint ADDR_LIMIT = 64'h1_0000_0000;
  localparam int NUM_PHASES = 10;
  localparam int ITEMS_PER_PHASE = 55;
  localparam int DRAIN_CYCLES = 45;

  class addr_scoreboard;
    logic [2:0]       dim_count;
    logic [63:0]      lower_bounds;
    logic [63:0]      upper_bounds;
    mdaag_pkg::out_t  expected_q[$];
    int               errors;
    int               checked;
    int               per_op[4];

    function new();
      dim_count    = 3'd1;
      lower_bounds = '0;
      upper_bounds = '0;
      errors       = 0;
      checked      = 0;
      per_op       = '{0, 0, 0, 0};
    endfunction

    function int dims_used();
      int d;
      d = int'(dim_count);
      if (d == 0) d = 1;
      if (d > mdaag_pkg::NUM_DIMS) d = mdaag_pkg::NUM_DIMS;
      return d;
    endfunction

    function longint bound_lo(int i);
      logic signed [15:0] s;
      s = lower_bounds[16*i +: 16];
      return longint'(s);
    endfunction

    function longint bound_hi(int i);
      logic signed [15:0] s;
      s = upper_bounds[16*i +: 16];
      return longint'(s);
    endfunction

    function longint extent(int i);
      return (bound_hi(i) >= bound_lo(i)) ? bound_hi(i) - bound_lo(i) + 1 : 0;
    endfunction

    // Number of elements, clamped at the address space size.
    function longint array_size();
      longint s;
      s = 1;
      for (int i = 0; i < dims_used(); i++) begin
        s = s * extent(i);
        if (s > ADDR_LIMIT) s = ADDR_LIMIT;
      end
      return s;
    endfunction

    function mdaag_pkg::out_t predict_address(mdaag_pkg::in_t x);
      mdaag_pkg::out_t res;
      int          d;
      int          k;
      longint      idx[4];
      longint      off[4];
      longint      a;
      longint      r;
      longint      c;
      logic [15:0] rc[4];
      logic [15:0] cc[4];
      bit          oor;
      res = '0;
      d   = dims_used();
      oor = 0;
      a   = 0;
      idx = '{longint'(x.index_0), longint'(x.index_1), longint'(x.index_2),
              longint'(x.index_3)};
      off = '{0, 0, 0, 0};
      rc  = '{16'd0, 16'd0, 16'd0, 16'd0};
      cc  = '{16'd0, 16'd0, 16'd0, 16'd0};
      if (x.op == mdaag_pkg::OP_ROW || x.op == mdaag_pkg::OP_COL) begin
        for (int i = 0; i < d; i++) begin
          if (idx[i] < bound_lo(i) || idx[i] > bound_hi(i)) oor = 1;
          else off[i] = idx[i] - bound_lo(i);
        end
        for (int i = 0; i < d && !oor; i++) begin
          k = (x.op == mdaag_pkg::OP_ROW) ? i : d - 1 - i;
          a = a * extent(k) + off[k];
          if (a >= ADDR_LIMIT) oor = 1;
        end
        res.linear_address = oor ? 32'd0 : a[31:0];
      end else if (x.op == mdaag_pkg::OP_DELIN) begin
        if (longint'(x.linear_index) >= array_size()) begin
          oor = 1;
        end else begin
          r = longint'(x.linear_index);
          for (int i = d - 1; i >= 0; i--) begin
            c = bound_lo(i) + (r % extent(i));
            rc[i] = c[15:0];
            r = r / extent(i);
          end
          r = longint'(x.linear_index);
          for (int i = 0; i < d; i++) begin
            c = bound_lo(i) + (r % extent(i));
            cc[i] = c[15:0];
            r = r / extent(i);
          end
        end
      end
      res.row_coord_0 = rc[0];
      res.row_coord_1 = rc[1];
      res.row_coord_2 = rc[2];
      res.row_coord_3 = rc[3];
      res.col_coord_0 = cc[0];
      res.col_coord_1 = cc[1];
      res.col_coord_2 = cc[2];
      res.col_coord_3 = cc[3];
      res.out_of_range = oor;
      return res;
    endfunction

    function void note_request(mdaag_pkg::in_t x);
      expected_q.push_back(predict_address(x));
      per_op[x.op]++;
    endfunction

    function void check_result(mdaag_pkg::out_t got);
      mdaag_pkg::out_t exp_r;
      bit   bad;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("ERROR: result with no request outstanding: %p", got);
        return;
      end
      exp_r = expected_q.pop_front();
      checked++;
      bad = (got.linear_address !== exp_r.linear_address) ||
            (got.row_coord_0 !== exp_r.row_coord_0) ||
            (got.row_coord_1 !== exp_r.row_coord_1) ||
            (got.row_coord_2 !== exp_r.row_coord_2) ||
            (got.row_coord_3 !== exp_r.row_coord_3) ||
            (got.col_coord_0 !== exp_r.col_coord_0) ||
            (got.col_coord_1 !== exp_r.col_coord_1) ||
            (got.col_coord_2 !== exp_r.col_coord_2) ||
            (got.col_coord_3 !== exp_r.col_coord_3) ||
            (got.out_of_range !== exp_r.out_of_range);
      if (bad) begin
        errors++;
        if (errors <= 10) begin
          $display("ERROR: result %0d mismatch", checked);
          $display("  expected %p", exp_r);
          $display("  actual   %p", got);
        end
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [mdaag_pkg::CFG_IDX_BITS-1:0] cfg_idx;
  logic [mdaag_pkg::CFG_BITS-1:0]     cfg_wdata;
  logic        in_valid;
  logic        in_stall;
  mdaag_pkg::in_t  in_d;
  logic        out_valid;
  logic        out_stall;
  mdaag_pkg::out_t out_d;

  addr_scoreboard sb;
  bit          calm;
  int          sent;
  int          hold;
  bit          long_hold_done;

  multi_dim_array_address_gen_top DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_i        (in_d),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_o       (out_d)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  // Result side: random stall bursts plus one long hold-off that backs up the pipe.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) sb.check_result(out_d);
      if (hold > 0) begin
        hold--;
      end else if (!long_hold_done && sent >= 120) begin
        hold = 300;
        long_hold_done = 1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        hold = $urandom_range(1, 18);
      end
      out_stall <= (hold > 0);
    end
  end

  function automatic logic [63:0] pack_bounds(int b0, int b1, int b2, int b3);
    logic [15:0] s0, s1, s2, s3;
    s0 = b0[15:0];
    s1 = b1[15:0];
    s2 = b2[15:0];
    s3 = b3[15:0];
    return {s3, s2, s1, s0};
  endfunction

  function automatic mdaag_pkg::in_t make_req(logic [1:0] op, int i0, int i1, int i2,
                                              int i3, logic [31:0] lin);
    mdaag_pkg::in_t x;
    x.op = op;
    x.index_0 = i0[15:0];
    x.index_1 = i1[15:0];
    x.index_2 = i2[15:0];
    x.index_3 = i3[15:0];
    x.linear_index = lin;
    return x;
  endfunction

  // Mostly in-bounds tuples and linear indices, the rest raw noise.
  function automatic mdaag_pkg::in_t random_req();
    mdaag_pkg::in_t x;
    int     pick;
    longint v;
    longint sz;
    logic [15:0] f[4];
    x = '0;
    x.linear_index = $urandom;
    pick = $urandom_range(0, 39);
    x.op = (pick == 0) ? OP_UNUSED : 2'($urandom_range(0, 2));
    for (int i = 0; i < mdaag_pkg::NUM_DIMS; i++) begin
      f[i] = 16'($urandom);
      if (i < sb.dims_used() && sb.extent(i) > 0 && $urandom_range(0, 9) != 0) begin
        v = sb.bound_lo(i) + longint'($urandom_range(0, 32'(sb.extent(i) - 1)));
        f[i] = v[15:0];
      end
    end
    x.index_0 = f[0];
    x.index_1 = f[1];
    x.index_2 = f[2];
    x.index_3 = f[3];
    sz = sb.array_size();
    pick = $urandom_range(0, 9);
    if (sz > 0 && pick < 7) x.linear_index = $urandom_range(0, 32'(sz - 1));
    else if (pick == 7 && sz < ADDR_LIMIT) x.linear_index = sz[31:0];
    return x;
  endfunction

  // Called at a rising edge; returns at the edge where the request was taken.
  task automatic send_req(mdaag_pkg::in_t x);
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_d <= x;
    do @(posedge clk); while (in_stall);
    sb.note_request(x);
    sent++;
  endtask

  task automatic write_reg(logic [mdaag_pkg::CFG_IDX_BITS-1:0] idx, logic [63:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      mdaag_pkg::CFG_DIM_COUNT:    sb.dim_count = val[2:0];
      mdaag_pkg::CFG_LOWER_BOUNDS: sb.lower_bounds = val;
      mdaag_pkg::CFG_UPPER_BOUNDS: sb.upper_bounds = val;
      default: ;
    endcase
  endtask

  task automatic configure(logic [2:0] dims, logic [63:0] lo, logic [63:0] hi);
    write_reg(mdaag_pkg::CFG_DIM_COUNT, {61'd0, dims});
    write_reg(mdaag_pkg::CFG_LOWER_BOUNDS, lo);
    write_reg(mdaag_pkg::CFG_UPPER_BOUNDS, hi);
    cfg_we <= 1'b0;
  endtask

  task automatic random_config();
    logic [63:0] lo;
    logic [63:0] hi;
    int b;
    lo = {$urandom, $urandom};
    hi = {$urandom, $urandom};
    for (int i = 0; i < mdaag_pkg::NUM_DIMS; i++) begin
      b = $urandom_range(0, 65535) - 32768;
      if (b > 32700) b = 32700;
      lo[16*i +: 16] = b[15:0];
      b = b + $urandom_range(0, 12);
      hi[16*i +: 16] = b[15:0];
    end
    configure(3'($urandom_range(0, 7)), lo, hi);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int n_dir;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_d = '0;
    out_stall = 1'b0;
    calm = 0;
    sent = 0;
    hold = 0;
    long_hold_done = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int p = 0; p < NUM_PHASES; p++) begin
      n_dir = sent;
      case (p)
        0: begin
          // Reset setting: one dimension holding only element 0.
          send_req(make_req(mdaag_pkg::OP_ROW, 0, 5, -7, 3, 0));
          send_req(make_req(mdaag_pkg::OP_DELIN, 0, 0, 0, 0, 0));
          send_req(make_req(mdaag_pkg::OP_DELIN, 0, 0, 0, 0, 1));
        end
        1: begin
          configure(3'd2, pack_bounds(-3, 5, 100, -100), pack_bounds(4, 9, 0, 0));
          send_req(make_req(mdaag_pkg::OP_ROW, -3, 5, 0, 0, 0));
          send_req(make_req(mdaag_pkg::OP_ROW, 4, 9, 0, 0, 0));
          send_req(make_req(mdaag_pkg::OP_COL, 4, 9, 32767, -32768, 0));
          send_req(make_req(mdaag_pkg::OP_COL, -3, 6, 0, 0, 32'hFFFF_FFFF));
          send_req(make_req(mdaag_pkg::OP_ROW, -4, 5, 0, 0, 0));
          send_req(make_req(mdaag_pkg::OP_COL, 4, 10, 0, 0, 0));
          send_req(make_req(mdaag_pkg::OP_ROW, -32768, 32767, 0, 0, 0));
          send_req(make_req(mdaag_pkg::OP_DELIN, 0, 0, 0, 0, 0));
          send_req(make_req(mdaag_pkg::OP_DELIN, 0, 0, 0, 0, 39));
          send_req(make_req(mdaag_pkg::OP_DELIN, 0, 0, 0, 0, 40));
          send_req(make_req(mdaag_pkg::OP_DELIN, 0, 0, 0, 0, 32'hFFFF_FFFF));
          send_req(make_req(OP_UNUSED, 1, 6, 0, 0, 3));
        end
        2: configure(3'd4, pack_bounds(-2, 0, 7, -32768), pack_bounds(1, 2, 9, -32765));
        3: begin
          // Full 16-bit range in every dimension overflows the address space.
          configure(3'd7, {4{16'h8000}}, {4{16'h7FFF}});
          send_req(make_req(mdaag_pkg::OP_ROW, 32767, 32767, 32767, 32767, 0));
          send_req(make_req(mdaag_pkg::OP_COL, -32768, -32768, -32768, -32768, 0));
          send_req(make_req(mdaag_pkg::OP_ROW, -32768, -32768, -32767, 0, 0));
          send_req(make_req(mdaag_pkg::OP_DELIN, 0, 0, 0, 0, 32'hFFFF_FFFF));
        end
        4: begin
          // Dimension 1 is empty, so nothing is in range.
          configure(3'd3, pack_bounds(0, 0, 0, 0), pack_bounds(5, -1, 3, 0));
          send_req(make_req(mdaag_pkg::OP_ROW, 1, 0, 1, 0, 0));
          send_req(make_req(mdaag_pkg::OP_DELIN, 0, 0, 0, 0, 0));
        end
        5: begin
          configure(3'd0, pack_bounds(-32768, 1, 2, 3), pack_bounds(32767, 0, 0, 0));
          send_req(make_req(mdaag_pkg::OP_DELIN, 0, 0, 0, 0, 65535));
          send_req(make_req(mdaag_pkg::OP_COL, 32767, 9, 9, 9, 0));
        end
        default: random_config();
      endcase
      n_dir = sent - n_dir;
      for (int k = n_dir; k < ITEMS_PER_PHASE; k++) begin
        if (sent > 480) calm = 1;
        send_req(random_req());
      end
      // The sender holds back here until every result of the phase is in.
      wait_drained();
    end

    $display("Sent %0d requests over %0d bound settings, %0d results checked.",
             sent, NUM_PHASES, sb.checked);
    $display("Row-major %0d, column-major %0d, delinearize %0d, unused op %0d.",
             sb.per_op[0], sb.per_op[1], sb.per_op[2], sb.per_op[3]);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
